FILE: hdl/indexed_sequence_store_macros.svh
// ----------------------------------------------------------------------------
// indexed_sequence_store_macros: assertion helpers
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_MACROS_SVH

// same-cycle implication
`define ISS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// shared sizes, codes and control types of the indexed sequence store
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int ACTION_W = 3;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT     = 3'd0,
    ACT_REMOVE_POS = 3'd1,
    ACT_REMOVE_VAL = 3'd2,
    ACT_READ       = 3'd3,
    ACT_WRITE      = 3'd4,
    ACT_FIND       = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BOUNDS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic match;
    logic exec;
  } iss_cmd_t;

endpackage

FILE: hdl/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store
// ordered store of signed words with insert, remove, read, write and find
// ----------------------------------------------------------------------------
// usage
//   in_*  : one action per transfer; in_tuser carries the action code,
//           in_tdata the position and the value
//   out_* : one result per action: read value, found position, entry count
//           and status
//   steps: each action passes a match step, then an execute step; the match
//           step registers the value compare across all cells, the execute
//           step picks the first match, shifts or updates the cells and
//           raises out_tvalid; a new action is taken in the execute step
//   when the output slot is free. the result sits in an output register, so the next action is taken
//   while a result waits; with the receiver stalled the block holds the
//   following result in its execute step and stops taking input
//   reset: entry count goes to zero and the output goes idle; cell contents
//   are not cleared and are only read below the count
// ----------------------------------------------------------------------------
`include "indexed_sequence_store_macros.svh"

module indexed_sequence_store
  import iss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[5:0], value[37:6], zero[39:38]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], found_position[36:32],
                                  // entry_count[42:37], status[45:43], zero[47:46]
);

  iss_cmd_t                     cmd;
  logic signed [DATA_WIDTH-1:0] read_value;
  logic [IDX_W-1:0]             found_position;
  logic [CNT_W-1:0]             entry_count;
  logic [STATUS_W-1:0]          status;

  iss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  iss_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_action          (in_tuser[ACTION_W-1:0]),
    .in_position        (in_tdata[POS_W-1:0]),
    .in_value           (in_tdata[POS_W+DATA_WIDTH-1:POS_W]),
    .out_read_value     (read_value),
    .out_found_position (found_position),
    .out_entry_count    (entry_count),
    .out_status         (status)
  );

  assign out_tdata = {2'b00, status, entry_count, found_position, read_value};

  `ISS_ASSERT_NOW(a_exec_slot_free, cmd.exec, !out_tvalid || out_tready,
    "execute step while output register still occupied")
  `ISS_ASSERT_NEXT(a_accept_then_match, in_tvalid && in_tready, cmd.match,
    "input transfer not followed by match step")
  `ISS_ASSERT_NEXT(a_exec_then_valid, cmd.exec, out_tvalid,
    "execute step did not present a result")
  `ISS_ASSERT_NOW(a_count_bound, out_tvalid, entry_count <= CNT_W'(CAPACITY),
    "entry count beyond capacity")

endmodule

FILE: hdl/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl
// sequencer: capture, match, execute; owns the output valid flag
// ----------------------------------------------------------------------------
module iss_ctrl
  import iss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output iss_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) || ((state_r == S_EXEC) && slot_free);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.load_in = accept;
    cmd.match   = (state_r == S_MATCH);
    cmd.exec    = (state_r == S_EXEC) && slot_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? S_MATCH : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/iss_datapath.sv
// ----------------------------------------------------------------------------
// iss_datapath
// entry cells, count, match vector, shift and update logic, result register
// ----------------------------------------------------------------------------
module iss_datapath
  import iss_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  iss_cmd_t                     cmd,
  input  logic [ACTION_W-1:0]          in_action,
  input  logic [POS_W-1:0]             in_position,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  output logic signed [DATA_WIDTH-1:0] out_read_value,
  output logic [IDX_W-1:0]             out_found_position,
  output logic [CNT_W-1:0]             out_entry_count,
  output logic [STATUS_W-1:0]          out_status
);

  logic [DATA_WIDTH-1:0] cells_r [CAPACITY];
  logic [DATA_WIDTH-1:0] cells_nxt [CAPACITY];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CAPACITY-1:0]   match_r, match_nxt;

  logic [ACTION_W-1:0]   action_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;

  logic [DATA_WIDTH-1:0] rd_nxt;
  logic [IDX_W-1:0]      fp_nxt;
  logic [STATUS_W-1:0]   st_nxt;
  logic [IDX_W-1:0]      first_idx;
  logic                  any_match;
  logic                  pos_in_range;
  logic [IDX_W-1:0]      pos_idx;

  assign pos_idx      = pos_r[IDX_W-1:0];
  assign pos_in_range = (CNT_W'(pos_r) < count_r);
  assign any_match    = |match_r;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (cells_r[i] == val_r) && (CNT_W'(i) < count_r);
    end
  end

  always_comb begin
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cells_nxt = cells_r;
    count_nxt = count_r;
    rd_nxt    = '0;
    fp_nxt    = '0;
    st_nxt    = ST_OK;
    case (action_r)
      ACT_INSERT: begin
        if (CNT_W'(pos_r) > count_r) begin
          st_nxt = ST_BOUNDS;
        end else if (count_r >= CNT_W'(CAPACITY)) begin
          st_nxt = ST_FULL;
        end else begin
          for (int i = 1; i < CAPACITY; i++) begin
            if (IDX_W'(i) > pos_idx) begin
              cells_nxt[i] = cells_r[i-1];
            end
          end
          cells_nxt[pos_idx] = val_r;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_REMOVE_POS: begin
        if (count_r == '0) begin
          st_nxt = ST_EMPTY;
        end else if (!pos_in_range) begin
          st_nxt = ST_BOUNDS;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= pos_idx) begin
              cells_nxt[i] = cells_r[i+1];
            end
          end
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_REMOVE_VAL: begin
        if (count_r == '0) begin
          st_nxt = ST_EMPTY;
        end else if (!any_match) begin
          st_nxt = ST_NOTFOUND;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= first_idx) begin
              cells_nxt[i] = cells_r[i+1];
            end
          end
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_READ: begin
        if (count_r == '0) begin
          st_nxt = ST_EMPTY;
        end else if (!pos_in_range) begin
          st_nxt = ST_BOUNDS;
        end else begin
          rd_nxt = cells_r[pos_idx];
        end
      end
      ACT_WRITE: begin
        if (count_r == '0) begin
          st_nxt = ST_EMPTY;
        end else if (!pos_in_range) begin
          st_nxt = ST_BOUNDS;
        end else begin
          cells_nxt[pos_idx] = val_r;
        end
      end
      ACT_FIND: begin
        if (count_r == '0) begin
          st_nxt = ST_EMPTY;
        end else if (!any_match) begin
          st_nxt = ST_NOTFOUND;
        end else begin
          fp_nxt = first_idx;
        end
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r <= in_action;
      pos_r    <= in_position;
      val_r    <= in_value;
    end
    if (cmd.match) begin
      match_r <= match_nxt;
    end
    if (cmd.exec) begin
      cells_r            <= cells_nxt;
      out_read_value     <= rd_nxt;
      out_found_position <= fp_nxt;
      out_entry_count    <= count_nxt;
      out_status         <= st_nxt;
    end
  end

endmodule

FILE: bench/iss_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iss_checker
// watches both streams of the indexed sequence store, keeps its own copy of
// the stored words, predicts the result of every accepted action and
// compares each result transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module iss_checker
  import iss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // position[5:0], value[37:6], zero[39:38]
  input  logic [2:0]  in_tuser,   // action[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // read_value[31:0], found_position[36:32],
                                  // entry_count[42:37], status[45:43], zero[47:46]
  output int          mismatches,
  output int          outstanding,
  output int          stored_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [ACTION_W-1:0]   action;
    logic [DATA_WIDTH-1:0] read_value;
    logic [IDX_W-1:0]      found_position;
    logic [CNT_W-1:0]      entry_count;
    status_t               status;
  } outcome_t;

  logic [DATA_WIDTH-1:0] stored_words[$];
  outcome_t              expected_outcomes[$];

  function automatic outcome_t apply_action(logic [ACTION_W-1:0] action,
                                            logic [POS_W-1:0] pos,
                                            logic [DATA_WIDTH-1:0] word);
    outcome_t res;
    int       first_hit;
    res.action         = action;
    res.read_value     = '0;
    res.found_position = '0;
    res.status         = ST_OK;
    first_hit          = -1;
    for (int i = stored_words.size() - 1; i >= 0; i--) begin
      if (stored_words[i] == word) first_hit = i;
    end
    case (action)
      ACT_INSERT: begin
        if (pos > stored_words.size()) res.status = ST_BOUNDS;
        else if (stored_words.size() >= CAPACITY) res.status = ST_FULL;
        else stored_words.insert(pos, word);
      end
      ACT_REMOVE_POS: begin
        if (stored_words.size() == 0) res.status = ST_EMPTY;
        else if (pos >= stored_words.size()) res.status = ST_BOUNDS;
        else stored_words.delete(pos);
      end
      ACT_REMOVE_VAL: begin
        if (stored_words.size() == 0) res.status = ST_EMPTY;
        else if (first_hit < 0) res.status = ST_NOTFOUND;
        else stored_words.delete(first_hit);
      end
      ACT_READ: begin
        if (stored_words.size() == 0) res.status = ST_EMPTY;
        else if (pos >= stored_words.size()) res.status = ST_BOUNDS;
        else res.read_value = stored_words[pos];
      end
      ACT_WRITE: begin
        if (stored_words.size() == 0) res.status = ST_EMPTY;
        else if (pos >= stored_words.size()) res.status = ST_BOUNDS;
        else stored_words[pos] = word;
      end
      ACT_FIND: begin
        if (stored_words.size() == 0) res.status = ST_EMPTY;
        else if (first_hit < 0) res.status = ST_NOTFOUND;
        else res.found_position = IDX_W'(first_hit);
      end
      default: begin
        // unused codes leave everything as it is
      end
    endcase
    res.entry_count = CNT_W'(stored_words.size());
    return res;
  endfunction

  task automatic report_failure(string text);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("checker: %s", text);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      stored_words.delete();
      expected_outcomes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_outcomes.size() == 0) begin
          report_failure($sformatf("result transfer %h with nothing pending", out_tdata));
        end else begin
          want = expected_outcomes.pop_front();
          if (out_tdata[31:0] !== want.read_value ||
              out_tdata[36:32] !== want.found_position ||
              out_tdata[42:37] !== want.entry_count ||
              out_tdata[45:43] !== want.status) begin
            report_failure($sformatf(
              "action %0d: expected rd=%h pos=%0d cnt=%0d st=%0d, got rd=%h pos=%0d cnt=%0d st=%0d",
              want.action, want.read_value, want.found_position, want.entry_count,
              want.status, out_tdata[31:0], out_tdata[36:32], out_tdata[42:37],
              out_tdata[45:43]));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_outcomes.push_back(apply_action(in_tuser, in_tdata[5:0], in_tdata[37:6]));
      end
    end
    outstanding  <= expected_outcomes.size();
    stored_count <= stored_words.size();
  end

endmodule

FILE: bench/tb_indexed_sequence_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_sequence_store
// drives actions into the indexed sequence store: a directed pass over empty,
// full, bounds and not-found cases, then random fill and drain traffic in
// three idling phases, with the checker judging every result transfer
// ----------------------------------------------------------------------------
module tb_indexed_sequence_store;
  import iss_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
  localparam int ITEMS_PER_PHASE = 435;
  localparam int RUN_LIMIT_NS    = 5_000_000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // position[5:0], value[37:6], zero[39:38]
  logic [2:0]  in_tuser   = '0;   // action[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // read_value[31:0], found_position[36:32],
                                  // entry_count[42:37], status[45:43], zero[47:46]

  int mismatches;
  int outstanding;
  int stored_count;
  int send_idle_pct = 29;
  int recv_idle_pct = 73;
  bit filling       = 1'b1;

  logic [31:0] value_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                  32'hffff_ffff, '0, '0, '0, '0};

  indexed_sequence_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  iss_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .stored_count (stored_count)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                           logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, word, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [ACTION_W-1:0] act;
    logic [POS_W-1:0]    pos;
    logic [31:0]         word;
    int                  roll;
    int                  cnt;
    int                  limit;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty sequence
    send_item(ACT_READ, 6'd0, 32'h0);
    send_item(ACT_REMOVE_POS, 6'd0, 32'h0);
    send_item(ACT_REMOVE_VAL, 6'd0, 32'h0);
    send_item(ACT_WRITE, 6'd0, 32'h1234_5678);
    send_item(ACT_FIND, 6'd0, 32'h0);
    send_item(ACT_INSERT, 6'd1, 32'h0);
    // append, front and middle inserts with extreme values
    send_item(ACT_INSERT, 6'd0, 32'h7fff_ffff);
    send_item(ACT_INSERT, 6'd1, 32'h8000_0000);
    send_item(ACT_INSERT, 6'd0, 32'hffff_ffff);
    send_item(ACT_INSERT, 6'd1, 32'h0000_0000);
    for (int i = 0; i < 4; i++) send_item(ACT_READ, 6'(i), 32'h0);
    send_item(ACT_READ, 6'd4, 32'h0);
    send_item(ACT_READ, 6'd32, 32'h0);
    send_item(ACT_WRITE, 6'd32, 32'h0);
    send_item(ACT_REMOVE_POS, 6'd4, 32'h0);
    send_item(ACT_WRITE, 6'd2, 32'h5555_5555);
    send_item(ACT_FIND, 6'd0, 32'h5555_5555);
    send_item(ACT_FIND, 6'd0, 32'haaaa_aaaa);
    send_item(ACT_REMOVE_VAL, 6'd0, 32'haaaa_aaaa);
    send_item(ACT_REMOVE_VAL, 6'd0, 32'hffff_ffff);
    send_item(ACT_REMOVE_POS, 6'd1, 32'h0);
    send_item(ACT_UNUSED_LO, 6'd0, 32'hdead_beef);
    send_item(ACT_UNUSED_HI, 6'd63, 32'hffff_ffff);
    // fill to capacity, then the full cases and the last slot
    while (stored_count < CAPACITY) send_item(ACT_INSERT, 6'(stored_count), $urandom());
    send_item(ACT_INSERT, 6'd0, 32'h0);
    send_item(ACT_INSERT, 6'd32, 32'h0);
    send_item(ACT_WRITE, 6'd31, 32'h2bad_cafe);
    send_item(ACT_READ, 6'd31, 32'h0);
    send_item(ACT_FIND, 6'd0, 32'h2bad_cafe);
    send_item(ACT_REMOVE_POS, 6'd31, 32'h0);
    send_item(ACT_REMOVE_POS, 6'd0, 32'h0);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 29 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 200) wait_drained();
        cnt = stored_count;
        if (cnt >= CAPACITY) filling = 1'b0;
        else if (cnt == 0) filling = 1'b1;
        else if ($urandom_range(99) < 3) filling = !filling;
        roll = $urandom_range(99);
        if (filling) begin
          act = (roll < 45) ? ACT_INSERT : (roll < 55) ? ACT_REMOVE_POS :
                (roll < 62) ? ACT_REMOVE_VAL : (roll < 75) ? ACT_READ :
                (roll < 87) ? ACT_WRITE : ACT_FIND;
        end else begin
          act = (roll < 15) ? ACT_INSERT : (roll < 40) ? ACT_REMOVE_POS :
                (roll < 60) ? ACT_REMOVE_VAL : (roll < 72) ? ACT_READ :
                (roll < 84) ? ACT_WRITE : ACT_FIND;
        end
        limit = (act == ACT_INSERT) ? cnt : cnt - 1;
        roll  = $urandom_range(99);
        if (roll < 85 && limit >= 0) pos = 6'($urandom_range(limit, 0));
        else if (roll < 95) pos = 6'($urandom_range(32, 0));
        else pos = (roll % 2) ? 6'(cnt) : 6'd32;
        roll = $urandom_range(99);
        if (roll < ((act == ACT_FIND || act == ACT_REMOVE_VAL) ? 75 : 45)) begin
          word = value_pool[$urandom_range(7)];
        end else begin
          word = $urandom();
        end
        send_item(act, pos, word);
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
